// File: src/psp_pkg.sv
// ----------------------------------------------------------------------------
// psp_pkg
// Shared constants and request/response types for the packet slot pool.
// ----------------------------------------------------------------------------
package psp_pkg;

  localparam int unsigned NUM_SLOTS = 16;
  localparam int unsigned PKT_BYTES = 512;

  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned LEN_W   = 10;
  localparam int unsigned OFF_W   = 13;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned REQ_W   = 3;
  localparam int unsigned STAT_W  = 2;

  // free ring in the lower half, pending ring in the upper half
  localparam int unsigned RING_DEPTH = 2 * NUM_SLOTS;
  localparam int unsigned RING_AW    = $clog2(RING_DEPTH);

  localparam logic [REQ_W-1:0] REQ_ACQUIRE = 3'd0;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_ENQUEUE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP     = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DISCARD = 3'd4;

  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_BUSY  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  length;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] out_slot;
    logic [LEN_W-1:0]  out_length;
    logic [OFF_W-1:0]  buffer_offset;
    logic [CNT_W-1:0]  pend_count;
    logic [CNT_W-1:0]  free_count;
  } rsp_t;

  typedef struct packed {
    logic               we;
    logic [RING_AW-1:0] waddr;
    logic [SLOT_W-1:0]  wdata;
    logic [RING_AW-1:0] raddr;
  } ring_port_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [LEN_W-1:0]  wdata;
    logic [SLOT_W-1:0] raddr;
  } len_port_t;

endpackage

// File: src/psp_ram.sv
// ----------------------------------------------------------------------------
// psp_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module psp_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 8,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: src/psp_ctrl.sv
// ----------------------------------------------------------------------------
// psp_ctrl
// Request sequencer: ring pointers, levels, reset-value flags and the
// response register, driving the ring and length memories.
// ----------------------------------------------------------------------------
module psp_ctrl import psp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  req_t              in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rsp_t              out_rsp_o,
  output ring_port_t        ring_o,
  input  logic [SLOT_W-1:0] ring_rdata_i,
  output len_port_t         len_o,
  input  logic [LEN_W-1:0]  len_rdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACQ,
    ST_POP_SLOT,
    ST_POP_LEN,
    ST_DISCARD,
    ST_HOLD
  } state_e;

  localparam logic [CNT_W-1:0]  LEVEL_FULL = CNT_W'(NUM_SLOTS);
  localparam logic [SLOT_W-1:0] PTR_LAST   = SLOT_W'(NUM_SLOTS - 1);

  function automatic logic [SLOT_W-1:0] ptr_next(logic [SLOT_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [OFF_W-1:0] slot_offset(logic [SLOT_W-1:0] s);
    logic [31:0] prod;
    prod = 32'(s) * 32'(PKT_BYTES);
    return prod[OFF_W-1:0];
  endfunction

  state_e                  state_q, state_d;
  logic [SLOT_W-1:0]       free_head_q, free_head_d;
  logic [SLOT_W-1:0]       free_tail_q, free_tail_d;
  logic [CNT_W-1:0]        free_level_q, free_level_d;
  logic [SLOT_W-1:0]       pend_head_q, pend_head_d;
  logic [SLOT_W-1:0]       pend_tail_q, pend_tail_d;
  logic [CNT_W-1:0]        pend_level_q, pend_level_d;
  logic [NUM_SLOTS-1:0]    free_vld_q, free_vld_d;
  logic [NUM_SLOTS-1:0]    len_vld_q, len_vld_d;
  logic                    rd_vld_q, rd_vld_d;
  logic [SLOT_W-1:0]       slot_q, slot_d;
  rsp_t                    res_q, res_d;
  rsp_t                    out_q, out_d;
  logic                    out_vld_q, out_vld_d;

  logic                    out_free;
  logic                    emit;
  rsp_t                    r;
  logic                    push_en;
  logic [SLOT_W-1:0]       push_slot;
  logic [SLOT_W-1:0]       rd_slot;

  assign out_free    = !out_vld_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_q;
  assign rd_slot     = ring_rdata_i;

  always_comb begin
    state_d      = state_q;
    free_head_d  = free_head_q;
    free_tail_d  = free_tail_q;
    free_level_d = free_level_q;
    pend_head_d  = pend_head_q;
    pend_tail_d  = pend_tail_q;
    pend_level_d = pend_level_q;
    free_vld_d   = free_vld_q;
    len_vld_d    = len_vld_q;
    rd_vld_d     = rd_vld_q;
    slot_d       = slot_q;
    res_d        = res_q;
    out_d        = out_q;
    out_vld_d    = out_vld_q;
    ring_o       = '0;
    len_o        = '0;
    r            = '0;
    r.status     = STATUS_OK;
    emit         = 1'b0;
    push_en      = 1'b0;
    push_slot    = '0;

    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_req_i.req_type)
            REQ_ACQUIRE: begin
              if (free_level_q == '0) begin
                r.status = STATUS_BUSY;
                emit     = 1'b1;
              end else begin
                ring_o.raddr = {1'b0, free_head_q};
                rd_vld_d     = free_vld_q[free_head_q];
                slot_d       = free_head_q;
                free_head_d  = ptr_next(free_head_q);
                free_level_d = free_level_q - 1'b1;
                state_d      = ST_ACQ;
              end
            end
            REQ_RELEASE: begin
              push_en   = 1'b1;
              push_slot = in_req_i.slot;
              emit      = 1'b1;
            end
            REQ_ENQUEUE: begin
              len_o.we    = 1'b1;
              len_o.waddr = in_req_i.slot;
              len_o.wdata = in_req_i.length;
              len_vld_d[in_req_i.slot] = 1'b1;
              if (pend_level_q == LEVEL_FULL) begin
                push_en   = 1'b1;
                push_slot = in_req_i.slot;
                r.status  = STATUS_BUSY;
              end else begin
                ring_o.we    = 1'b1;
                ring_o.waddr = {1'b1, pend_tail_q};
                ring_o.wdata = in_req_i.slot;
                pend_tail_d  = ptr_next(pend_tail_q);
                pend_level_d = pend_level_q + 1'b1;
              end
              emit = 1'b1;
            end
            REQ_POP, REQ_DISCARD: begin
              if (pend_level_q == '0) begin
                r.status = (in_req_i.req_type == REQ_POP) ? STATUS_EMPTY : STATUS_OK;
                emit     = 1'b1;
              end else begin
                ring_o.raddr = {1'b1, pend_head_q};
                pend_head_d  = ptr_next(pend_head_q);
                pend_level_d = pend_level_q - 1'b1;
                state_d      = (in_req_i.req_type == REQ_POP) ? ST_POP_SLOT : ST_DISCARD;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      ST_ACQ: begin
        r.out_slot      = rd_vld_q ? rd_slot : slot_q;
        r.buffer_offset = slot_offset(r.out_slot);
        emit            = 1'b1;
      end
      ST_POP_SLOT: begin
        len_o.raddr = rd_slot;
        rd_vld_d    = len_vld_q[rd_slot];
        slot_d      = rd_slot;
        state_d     = ST_POP_LEN;
      end
      ST_POP_LEN: begin
        r.out_slot      = slot_q;
        r.out_length    = rd_vld_q ? len_rdata_i : '0;
        r.buffer_offset = slot_offset(slot_q);
        emit            = 1'b1;
      end
      ST_DISCARD: begin
        push_en   = 1'b1;
        push_slot = rd_slot;
        if (pend_level_q != '0) begin
          ring_o.raddr = {1'b1, pend_head_q};
          pend_head_d  = ptr_next(pend_head_q);
          pend_level_d = pend_level_q - 1'b1;
        end else begin
          emit = 1'b1;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // give a slot back: length reads as zero, push free if room
    if (push_en) begin
      len_vld_d[push_slot] = 1'b0;
      if (free_level_q != LEVEL_FULL) begin
        ring_o.we    = 1'b1;
        ring_o.waddr = {1'b0, free_tail_q};
        ring_o.wdata = push_slot;
        free_vld_d[free_tail_q] = 1'b1;
        free_tail_d  = ptr_next(free_tail_q);
        free_level_d = free_level_q + 1'b1;
      end
    end

    r.pend_count = pend_level_d;
    r.free_count = free_level_d;

    if (emit) begin
      if (out_free) begin
        out_d     = r;
        out_vld_d = 1'b1;
        state_d   = ST_IDLE;
      end else begin
        res_d   = r;
        state_d = ST_HOLD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      free_head_q  <= '0;
      free_tail_q  <= '0;
      free_level_q <= LEVEL_FULL;
      pend_head_q  <= '0;
      pend_tail_q  <= '0;
      pend_level_q <= '0;
      free_vld_q   <= '0;
      len_vld_q    <= '0;
      rd_vld_q     <= 1'b0;
      slot_q       <= '0;
      res_q        <= '0;
      out_q        <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      free_head_q  <= free_head_d;
      free_tail_q  <= free_tail_d;
      free_level_q <= free_level_d;
      pend_head_q  <= pend_head_d;
      pend_tail_q  <= pend_tail_d;
      pend_level_q <= pend_level_d;
      free_vld_q   <= free_vld_d;
      len_vld_q    <= len_vld_d;
      rd_vld_q     <= rd_vld_d;
      slot_q       <= slot_d;
      res_q        <= res_d;
      out_q        <= out_d;
      out_vld_q    <= out_vld_d;
    end
  end

endmodule

// File: src/packet_slot_pool.sv
// ----------------------------------------------------------------------------
// packet_slot_pool
// Packet buffer slot pool with free ring, pending queue and length table.
// ----------------------------------------------------------------------------
// Each request gives one response. Release, enqueue, an empty pop or discard,
// an acquire with no free slot and unknown request types are answered from
// the idle state; acquire waits for the registered read of the ring memory
// and a pending pop also for the dependent read of the length memory.
// Discard goes through the pending slots one by one, one ring read and one
// free-ring write each cycle. Both rings share one 32-entry memory and
// lengths sit in a 16-entry memory; reset values come from per-entry flags,
// so there is no clearing pass and requests are taken straight after reset.
// A new request is taken while the previous response still waits in the
// output register.
module packet_slot_pool import psp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  ring_port_t        ring;
  len_port_t         len;
  logic [SLOT_W-1:0] ring_rdata;
  logic [LEN_W-1:0]  len_rdata;

  psp_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_req_i     (in_req_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_rsp_o    (out_rsp_o),
    .ring_o       (ring),
    .ring_rdata_i (ring_rdata),
    .len_o        (len),
    .len_rdata_i  (len_rdata)
  );

  psp_ram #(
    .DEPTH (RING_DEPTH),
    .WIDTH (SLOT_W)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ring.we),
    .waddr_i (ring.waddr),
    .wdata_i (ring.wdata),
    .raddr_i (ring.raddr),
    .rdata_o (ring_rdata)
  );

  psp_ram #(
    .DEPTH (NUM_SLOTS),
    .WIDTH (LEN_W)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len.we),
    .waddr_i (len.waddr),
    .wdata_i (len.wdata),
    .raddr_i (len.raddr),
    .rdata_o (len_rdata)
  );

endmodule

// File: tb/sv/tb_packet_slot_pool.sv
// ----------------------------------------------------------------------------
// tb_packet_slot_pool
// Self-checking bench for the packet slot pool. A short table of directed
// requests is followed by random request sequences: slot life cycles with
// random content, acquire, enqueue and release floods, and some noise. Both
// sides idle and stall in random bursts. A behavioural model of the free
// ring, pending queue and length table predicts every response that the
// directed table does not give, and all responses are checked in order.
// ----------------------------------------------------------------------------
module tb_packet_slot_pool;
  import psp_pkg::*;

  localparam int unsigned REQ_TOTAL   = 1750;
  localparam int unsigned HOLD_AT     = 400;
  localparam int unsigned DRAIN_AT    = 900;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DOG_LIMIT   = 3000;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned HELD_MAX    = 64;
  localparam int unsigned REPORT_MAX  = 10;

  localparam logic [REQ_W-1:0] REQ_UNDEF_A = 3'd5;
  localparam logic [REQ_W-1:0] REQ_UNDEF_B = 3'd6;
  localparam logic [REQ_W-1:0] REQ_UNDEF_C = 3'd7;

  localparam rsp_t NO_RSP = '0;

  typedef struct packed {
    req_t req;
    logic typed;
    rsp_t want;
  } step_row_t;

  typedef enum logic [1:0] {SEQ_GRAB, SEQ_STUFF, SEQ_SCATTER, SEQ_FLOW} seq_kind_e;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  req_t in_req_i    = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_rsp_o;

  packet_slot_pool u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // pool model
  logic [SLOT_W-1:0] spare_ring [NUM_SLOTS];
  logic [SLOT_W-1:0] spare_rd;
  logic [SLOT_W-1:0] spare_wr;
  logic [CNT_W-1:0]  spare_cnt;
  logic [SLOT_W-1:0] queued_ring [NUM_SLOTS];
  logic [SLOT_W-1:0] queued_rd;
  logic [SLOT_W-1:0] queued_wr;
  logic [CNT_W-1:0]  queued_cnt;
  logic [LEN_W-1:0]  len_tab [NUM_SLOTS];

  rsp_t              rsp_due_q [$];
  logic [SLOT_W-1:0] held_q [$];
  int unsigned       items_sent = 0;
  int unsigned       fail_cnt   = 0;
  bit                idle_en    = 1'b1;
  bit                hold_req   = 1'b0;

  function automatic void pool_reset();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      spare_ring[i]  = SLOT_W'(i);
      queued_ring[i] = '0;
      len_tab[i]     = '0;
    end
    spare_rd   = '0;
    spare_wr   = '0;
    spare_cnt  = CNT_W'(NUM_SLOTS);
    queued_rd  = '0;
    queued_wr  = '0;
    queued_cnt = '0;
  endfunction

  // a push onto a full free ring is dropped, the length is cleared anyway
  function automatic void slot_give_back(logic [SLOT_W-1:0] s);
    len_tab[s] = '0;
    if (spare_cnt < NUM_SLOTS) begin
      spare_ring[spare_wr] = s;
      spare_wr++;
      spare_cnt++;
    end
  endfunction

  function automatic rsp_t pool_rsp(req_t r);
    rsp_t              o;
    logic [SLOT_W-1:0] s;
    o = '0;
    case (r.req_type)
      REQ_ACQUIRE: begin
        if (spare_cnt == 0) begin
          o.status = STATUS_BUSY;
        end else begin
          s = spare_ring[spare_rd];
          spare_rd++;
          spare_cnt--;
          o.out_slot      = s;
          o.buffer_offset = OFF_W'(s * PKT_BYTES);
        end
      end
      REQ_RELEASE: slot_give_back(r.slot);
      REQ_ENQUEUE: begin
        len_tab[r.slot] = r.length;
        if (queued_cnt == NUM_SLOTS) begin
          slot_give_back(r.slot);
          o.status = STATUS_BUSY;
        end else begin
          queued_ring[queued_wr] = r.slot;
          queued_wr++;
          queued_cnt++;
        end
      end
      REQ_POP: begin
        if (queued_cnt == 0) begin
          o.status = STATUS_EMPTY;
        end else begin
          s = queued_ring[queued_rd];
          queued_rd++;
          queued_cnt--;
          o.out_slot      = s;
          o.out_length    = len_tab[s];
          o.buffer_offset = OFF_W'(s * PKT_BYTES);
        end
      end
      REQ_DISCARD: begin
        while (queued_cnt != 0) begin
          s = queued_ring[queued_rd];
          queued_rd++;
          queued_cnt--;
          slot_give_back(s);
        end
      end
      default: ;
    endcase
    o.pend_count = queued_cnt;
    o.free_count = spare_cnt;
    return o;
  endfunction

  function automatic logic [SLOT_W-1:0] take_held();
    int unsigned       idx;
    logic [SLOT_W-1:0] s;
    idx = $urandom_range(0, held_q.size() - 1);
    s   = held_q[idx];
    held_q.delete(idx);
    return s;
  endfunction

  function automatic void check_rsp(rsp_t got);
    rsp_t exp_r;
    bit   bad;
    if (rsp_due_q.size() == 0) begin
      fail_cnt++;
      if (fail_cnt <= REPORT_MAX)
        $display("unexpected response st=%0d slot=%0d len=%0d off=%0d pend=%0d free=%0d",
                 got.status, got.out_slot, got.out_length, got.buffer_offset,
                 got.pend_count, got.free_count);
    end else begin
      exp_r = rsp_due_q.pop_front();
      bad = (got.status !== exp_r.status) || (got.out_slot !== exp_r.out_slot) ||
            (got.out_length !== exp_r.out_length) ||
            (got.buffer_offset !== exp_r.buffer_offset) ||
            (got.pend_count !== exp_r.pend_count) ||
            (got.free_count !== exp_r.free_count);
      if (bad) begin
        fail_cnt++;
        if (fail_cnt <= REPORT_MAX) begin
          $display("mismatch exp st=%0d slot=%0d len=%0d off=%0d pend=%0d free=%0d",
                   exp_r.status, exp_r.out_slot, exp_r.out_length, exp_r.buffer_offset,
                   exp_r.pend_count, exp_r.free_count);
          $display("         got st=%0d slot=%0d len=%0d off=%0d pend=%0d free=%0d",
                   got.status, got.out_slot, got.out_length, got.buffer_offset,
                   got.pend_count, got.free_count);
        end
      end
    end
  endfunction

  task automatic offer(input req_t r, input logic typed, input rsp_t want);
    rsp_t        pred;
    int unsigned gap;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, 15);
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = pool_rsp(r);
    rsp_due_q.push_back(typed ? want : pred);
    if ((r.req_type == REQ_ACQUIRE || r.req_type == REQ_POP) &&
        pred.status == STATUS_OK && held_q.size() < HELD_MAX)
      held_q.push_back(pred.out_slot);
    items_sent++;
  endtask

  // request side
  initial begin
    step_row_t   dir_tab [$];
    req_t        r;
    seq_kind_e   seq;
    int unsigned roll;
    int unsigned pick;
    int unsigned burst;
    bit          hold_done;
    bit          drain_done;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    pool_reset();

    dir_tab.push_back({REQ_POP, 4'd0, 10'd0, 1'b1,
                       STATUS_EMPTY, 4'd0, 10'd0, 13'd0, 5'd0, 5'd16});
    dir_tab.push_back({REQ_DISCARD, 4'd0, 10'd0, 1'b1,
                       STATUS_OK, 4'd0, 10'd0, 13'd0, 5'd0, 5'd16});
    dir_tab.push_back({REQ_RELEASE, 4'd15, 10'd1023, 1'b1,
                       STATUS_OK, 4'd0, 10'd0, 13'd0, 5'd0, 5'd16});
    dir_tab.push_back({REQ_ACQUIRE, 4'd0, 10'd0, 1'b1,
                       STATUS_OK, 4'd0, 10'd0, 13'd0, 5'd0, 5'd15});
    dir_tab.push_back({REQ_ACQUIRE, 4'd15, 10'd1023, 1'b1,
                       STATUS_OK, 4'd1, 10'd0, 13'd512, 5'd0, 5'd14});
    dir_tab.push_back({REQ_ENQUEUE, 4'd0, 10'd0, 1'b1,
                       STATUS_OK, 4'd0, 10'd0, 13'd0, 5'd1, 5'd14});
    dir_tab.push_back({REQ_ENQUEUE, 4'd1, 10'd1023, 1'b1,
                       STATUS_OK, 4'd0, 10'd0, 13'd0, 5'd2, 5'd14});
    dir_tab.push_back({REQ_POP, 4'd0, 10'd0, 1'b1,
                       STATUS_OK, 4'd0, 10'd0, 13'd0, 5'd1, 5'd14});
    dir_tab.push_back({REQ_POP, 4'd0, 10'd0, 1'b1,
                       STATUS_OK, 4'd1, 10'd1023, 13'd512, 5'd0, 5'd14});
    dir_tab.push_back({REQ_ENQUEUE, 4'd15, 10'd512, 1'b0, NO_RSP});
    dir_tab.push_back({REQ_ENQUEUE, 4'd0, 10'd1, 1'b0, NO_RSP});
    dir_tab.push_back({REQ_DISCARD, 4'd0, 10'd0, 1'b0, NO_RSP});
    dir_tab.push_back({REQ_UNDEF_A, 4'd15, 10'd1023, 1'b0, NO_RSP});
    dir_tab.push_back({REQ_UNDEF_B, 4'd15, 10'd1023, 1'b0, NO_RSP});
    dir_tab.push_back({REQ_UNDEF_C, 4'd15, 10'd1023, 1'b0, NO_RSP});
    dir_tab.push_back({REQ_RELEASE, 4'd1, 10'd0, 1'b0, NO_RSP});
    dir_tab.push_back({REQ_ACQUIRE, 4'd0, 10'd0, 1'b0, NO_RSP});
    dir_tab.push_back({REQ_ENQUEUE, 4'd10, 10'd682, 1'b0, NO_RSP});
    dir_tab.push_back({REQ_ENQUEUE, 4'd5, 10'd341, 1'b0, NO_RSP});
    dir_tab.push_back({REQ_POP, 4'd0, 10'd0, 1'b0, NO_RSP});
    dir_tab.push_back({REQ_POP, 4'd0, 10'd0, 1'b0, NO_RSP});
    dir_tab.push_back({REQ_POP, 4'd0, 10'd0, 1'b0, NO_RSP});

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) offer(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want);

    while (items_sent < REQ_TOTAL) begin
      idle_en = (items_sent < REQ_TOTAL * 85 / 100) && ($urandom_range(0, 3) != 0);
      if (!hold_done && items_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_req  = 1'b1;
      end
      if (!drain_done && items_sent >= DRAIN_AT) begin
        drain_done = 1'b1;
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (rsp_due_q.size() != 0);
      end
      roll  = $urandom_range(0, 19);
      seq   = (roll == 0) ? SEQ_GRAB : (roll == 1) ? SEQ_STUFF :
              (roll == 2) ? SEQ_SCATTER : SEQ_FLOW;
      burst = (seq == SEQ_FLOW) ? $urandom_range(6, 24) : $urandom_range(17, 20);
      repeat (burst) begin
        r.slot   = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
        r.length = ($urandom_range(0, 4) == 0) ? LEN_W'($urandom_range(0, 1023)) :
                                                 LEN_W'($urandom_range(0, PKT_BYTES));
        case (seq)
          SEQ_GRAB:    r.req_type = REQ_ACQUIRE;
          SEQ_STUFF:   r.req_type = REQ_ENQUEUE;
          SEQ_SCATTER: r.req_type = REQ_RELEASE;
          default: begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
              r.req_type = REQ_ACQUIRE;
            end else if (pick < 55 && held_q.size() != 0) begin
              r.req_type = REQ_ENQUEUE;
              r.slot     = take_held();
            end else if (pick < 75) begin
              r.req_type = REQ_POP;
            end else if (pick < 92 && held_q.size() != 0) begin
              r.req_type = REQ_RELEASE;
              r.slot     = take_held();
            end else if (pick < 95) begin
              r.req_type = REQ_DISCARD;
            end else begin
              r.req_type = REQ_W'($urandom_range(0, REQ_UNDEF_C));
            end
          end
        endcase
        offer(r, 1'b0, NO_RSP);
      end
    end

    in_valid_i <= 1'b0;
    while (rsp_due_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // response side
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) check_rsp(out_rsp_o);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && idle_en && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 15);
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < DOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
